>>> rtl/core/cpa_pkg.sv
// Shared types and codes for the contiguous page allocator.
package cpa_pkg;

  localparam int CNT_W  = 11;
  localparam int PAGE_W = 10;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD     = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // One page map entry: taken flag and owning block start page.
  typedef struct packed {
    logic             taken;
    logic [CNT_W-1:0] owner;
  } entry_t;

endpackage

>>> rtl/core/cpa_page_map.sv
// Page map memory with a clearing pass after reset.
module cpa_page_map import cpa_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data,
  output logic          ready
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  entry_t        mem [DEPTH];
  entry_t        rd_q_r;
  logic [AW-1:0] clr_r;
  logic          clearing_r;

  // Sweep every entry to free once after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
  end

  assign rd_data = rd_q_r;
  assign ready   = !clearing_r;

endmodule

>>> rtl/core/contiguous_page_allocator.sv
// Top level of the first-fit contiguous page allocator.
//
// Requests enter on start with in_op, in_request_count and in_block_page and
// are taken at a clock edge where start is high and busy is low. One result
// per request appears on out_status, out_result_page and out_page_count for a
// single cycle, marked by out_valid; the receiver cannot stall it.
// The page count register is written on cfg_valid (cfg_ready is always high);
// the user must write it only while the block is idle; the block does not enforce it.
// After reset a clearing pass frees the page map: busy stays high until the
// pass ends. The map lives in one memory with a registered read.
// Request handling, with B = min(pages_in_use, MAX_PAGES):
//   zero-count allocate or out-of-range free: result in the cycle after start;
//   allocate: linear scan from BASE_PAGE up to B, ending at the first fit, then
//   marking of the N pages (one map write per page), then the result;
//   free: a linear scan from BASE_PAGE up to B, a read-modify-write pipeline over the
//   map, one page per cycle.
// One request is in flight at a time; the map has a single read port and a
// single write port.
module contiguous_page_allocator import cpa_pkg::*; #(
  parameter int MAX_PAGES = 1024,
  parameter int BASE_PAGE = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_op,
  input  logic [CNT_W-1:0]  in_request_count,
  input  logic [PAGE_W-1:0] in_block_page,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [PAGE_W-1:0] out_result_page,
  output logic [CNT_W-1:0]  out_page_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_pages_in_use
);

  localparam int AW        = $clog2(MAX_PAGES);
  localparam int BOUND_CAP = (MAX_PAGES > 2047) ? 2047 : MAX_PAGES;
  localparam logic [CNT_W-1:0] FIRST = CNT_W'(BASE_PAGE);
  localparam logic [CNT_W-1:0] CAP   = CNT_W'(BOUND_CAP);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MARK} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cfg_pages_r;
  logic              op_r, op_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [PAGE_W-1:0] blk_r, blk_nxt;
  logic [CNT_W-1:0]  bound_r, bound_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;        // read issue pointer, mark pointer
  logic [CNT_W-1:0]  ptr_d_r, ptr_d_nxt;    // page whose read data is back
  logic              vld_r, vld_nxt;
  logic [CNT_W-1:0]  run_len_r, run_len_nxt;
  logic [CNT_W-1:0]  run_start_r, run_start_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic              map_ready;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_q;

  logic [CNT_W-1:0]  bound_w;
  logic              issue;
  logic [CNT_W-1:0]  len_w;
  logic [CNT_W-1:0]  st_w;
  logic [CNT_W-1:0]  blk_ext_in;

  // Widen or narrow a page number to a map address.
  function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] p);
    logic [31:0] w;
    w = {{(32-CNT_W){1'b0}}, p};
    return w[AW-1:0];
  endfunction

  cpa_page_map #(
    .DEPTH (MAX_PAGES),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_q),
    .ready   (map_ready)
  );

  // Search bound: the configured count, capped by the map size.
  assign bound_w    = (cfg_pages_r < CAP) ? cfg_pages_r : CAP;
  assign blk_ext_in = {1'b0, in_block_page};
  assign issue      = (ptr_r < bound_r);
  assign len_w      = run_len_r + 1'b1;
  assign st_w       = (run_len_r == '0) ? ptr_d_r : run_start_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    n_nxt         = n_r;
    blk_nxt       = blk_r;
    bound_nxt     = bound_r;
    ptr_nxt       = ptr_r;
    ptr_d_nxt     = ptr_d_r;
    vld_nxt       = vld_r;
    run_len_nxt   = run_len_r;
    run_start_nxt = run_start_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_page_nxt  = out_page_r;
    out_count_nxt = out_count_r;
    wr_en         = 1'b0;
    wr_addr       = to_addr(ptr_d_r);
    wr_data       = '0;
    rd_addr       = to_addr(ptr_r);

    unique case (state_r)
      S_IDLE: begin
        if (start && map_ready) begin
          op_nxt      = in_op;
          n_nxt       = in_request_count;
          blk_nxt     = in_block_page;
          bound_nxt   = bound_w;
          ptr_nxt     = FIRST;
          vld_nxt     = 1'b0;
          run_len_nxt = '0;
          cnt_nxt     = '0;
          if (in_op == OP_ALLOC && in_request_count == '0) begin
            // Reject a zero-count allocate at once.
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_BAD;
            out_page_nxt   = '0;
            out_count_nxt  = '0;
          end else if (in_op == OP_FREE && (blk_ext_in < FIRST || blk_ext_in >= bound_w)) begin
            // A free outside the usable range releases nothing.
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_BAD;
            out_page_nxt   = in_block_page;
            out_count_nxt  = '0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read a cycle until the bound.
        vld_nxt = issue;
        if (issue) begin
          ptr_nxt   = ptr_r + 1'b1;
          ptr_d_nxt = ptr_r;
        end
        if (vld_r) begin
          if (op_r == OP_ALLOC) begin
            if (rd_q.taken) begin
              run_len_nxt = '0;
            end else begin
              run_start_nxt = st_w;
              if (len_w == n_r) begin
                // First fit found: mark the run from its start.
                state_nxt   = S_MARK;
                ptr_nxt     = st_w;
                run_len_nxt = n_r;
              end else begin
                run_len_nxt = len_w;
              end
            end
          end else if (rd_q.taken && rd_q.owner == {1'b0, blk_r}) begin
            // Release the page back to itself; the next read is a later page.
            wr_en         = 1'b1;
            wr_addr       = to_addr(ptr_d_r);
            wr_data.taken = 1'b0;
            wr_data.owner = ptr_d_r;
            cnt_nxt       = cnt_r + 1'b1;
          end
        end else if (!issue) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (op_r == OP_ALLOC) begin
            out_status_nxt = STAT_NOSPACE;
            out_page_nxt   = '0;
            out_count_nxt  = '0;
          end else begin
            out_status_nxt = (cnt_r != '0) ? STAT_OK : STAT_BAD;
            out_page_nxt   = blk_r;
            out_count_nxt  = cnt_r;
          end
        end
      end

      S_MARK: begin
        wr_en         = 1'b1;
        wr_addr       = to_addr(ptr_r);
        wr_data.taken = 1'b1;
        wr_data.owner = run_start_r;
        ptr_nxt       = ptr_r + 1'b1;
        run_len_nxt   = run_len_r - 1'b1;
        if (run_len_r == CNT_W'(1)) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_page_nxt   = run_start_r[PAGE_W-1:0];
          out_count_nxt  = n_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request payload and scan datapath: no reset needed.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    n_r          <= n_nxt;
    blk_r        <= blk_nxt;
    bound_r      <= bound_nxt;
    ptr_r        <= ptr_nxt;
    ptr_d_r      <= ptr_d_nxt;
    run_len_r    <= run_len_nxt;
    run_start_r  <= run_start_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Page count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pages_r <= CNT_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      cfg_pages_r <= cfg_pages_in_use;
    end
  end

  assign cfg_ready       = 1'b1;
  assign busy            = (state_r != S_IDLE) || !map_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_page = out_page_r;
  assign out_page_count  = out_count_r;

  // No result may leave while the clearing pass still runs.
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    !map_ready |-> !out_valid)
    else $error("result strobe during map clearing pass");

  // A zero-count allocate is rejected in the next cycle.
  a_zero_count_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_ALLOC && in_request_count == '0)
      |=> (out_valid && out_status == STAT_BAD && out_page_count == '0))
    else $error("zero-count allocate not rejected");

  // A successful allocate reports the requested count.
  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && op_r == OP_ALLOC && out_status == STAT_OK) |-> (out_page_count == n_r))
    else $error("allocate result count differs from request");

  // Marking writes the map every cycle.
  a_mark_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> (wr_en && wr_data.taken))
    else $error("marking cycle without a map write");

endmodule
